// ===== hdl/ptvs_pkg.sv =====
// shared types, constants and helper functions for the pose to velocity smoother
// no dependencies; imported by every module in the project
package ptvs_pkg;

   // input word: one timestamped planar pose
   typedef struct packed {
      logic        [31:0] stamp_us;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
   } req_word_type;

   // output word: middle pose and smoothed rates
   typedef struct packed {
      logic        [31:0] mid_stamp_us;
      logic signed [31:0] mid_pos_x;
      logic signed [31:0] mid_pos_y;
      logic signed [15:0] mid_heading;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
   } rsp_word_type;

   // sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_GO,
      ST_RATE_WAIT,
      ST_SHIFT,
      ST_FIR,
      ST_ROT,
      ST_GAIN,
      ST_SEND
   } ptvs_state_type;

   // states of the serial rate unit
   typedef enum logic [2:0] {
      RU_IDLE,
      RU_MUL,
      RU_DIV,
      RU_SAT,
      RU_DONE
   } ptvs_ru_state_type;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFORM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_FIRST = 3'd1;

   // tap registers and their reset weights (normalised gaussian, sigma 2)
   localparam int NUM_TAP_REGS = 5;
   localparam int TAP_IDX_W    = 3;
   localparam logic [15:0] TAP_RESET [NUM_TAP_REGS] = '{
      16'd9992, 16'd14539, 16'd16474, 16'd14539, 16'd9992
   };

   // rate unit: magnitude times one million, then restoring division
   localparam int MUL_BITS = 20;
   localparam logic [MUL_BITS-1:0] US_PER_S = 20'd1000000;
   localparam int QUO_BITS = 53;

   // cordic rotation
   localparam int CORDIC_STEPS = 16;
   localparam int CX_W = 36;
   localparam int CZ_W = 25;
   localparam int GAIN_Q30 = 652032874;
   localparam logic [15:0] GAIN_LO = 16'(GAIN_Q30 % 32768);
   localparam logic [15:0] GAIN_HI = 16'(GAIN_Q30 / 32768);

   // wide accumulator and shared multiplier product
   localparam int ACC_W  = 68;
   localparam int PROD_W = 53;

   // arctangent table, 2^24 units per turn
   function automatic logic signed [CZ_W-1:0] cordic_atan(input logic [3:0] i);
      logic signed [CZ_W-1:0] r;
      case (i)
         4'd0:    r = 25'sd2097152;
         4'd1:    r = 25'sd1238021;
         4'd2:    r = 25'sd654136;
         4'd3:    r = 25'sd332050;
         4'd4:    r = 25'sd166669;
         4'd5:    r = 25'sd83416;
         4'd6:    r = 25'sd41718;
         4'd7:    r = 25'sd20860;
         4'd8:    r = 25'sd10430;
         4'd9:    r = 25'sd5215;
         4'd10:   r = 25'sd2608;
         4'd11:   r = 25'sd1304;
         4'd12:   r = 25'sd652;
         4'd13:   r = 25'sd326;
         4'd14:   r = 25'sd163;
         4'd15:   r = 25'sd81;
         default: r = 25'sd0;
      endcase
      return r;
   endfunction

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > $signed({36'd0, 32'h7FFF_FFFF}))
         r = 32'sh7FFF_FFFF;
      else if (v < $signed({{36{1'b1}}, 32'h8000_0000}))
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ===== hdl/pose_to_velocity_smoother_top.sv =====
// pose to velocity smoother: finite difference rates, fir smoothing, optional rotation
// depends on ptvs_pkg and ptvs_rate_unit
// sequence per pose: three serial rates (start, multiply, divide, saturate, done each), shift,
// fir per channel, then rotation and gain when the transform bit is set, send; the first TAPS
// poses give no word; one pose at a time, req_stall is high until the word is sent
// reset clears the sequencer and control registers, not the datapath registers
module pose_to_velocity_smoother_top
   import ptvs_pkg::*;
#(
   parameter int TAPS = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int FILL_W = $clog2(TAPS + 2);
   localparam int IDX_W  = $clog2(TAPS);
   localparam int CNT_W  = 5;
   localparam int MID    = TAPS / 2;

   ptvs_state_type state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [1:0]          ch_ff;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_ff;
   logic                transform_ff;
   logic [15:0]         tap_ff [NUM_TAP_REGS];

   req_word_type        in_ff;
   logic [31:0]         stamp_ring_ff [TAPS];
   logic signed [31:0]  x_ring_ff     [TAPS];
   logic signed [31:0]  y_ring_ff     [TAPS];
   logic signed [15:0]  hd_ring_ff    [TAPS];
   logic signed [31:0]  vx_hist_ff    [TAPS];
   logic signed [31:0]  vy_hist_ff    [TAPS];
   logic signed [31:0]  wz_hist_ff    [TAPS];
   logic signed [31:0]  rate_new_ff   [3];
   logic signed [31:0]  fir_ff        [3];
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [CX_W-1:0]   cx_ff, cy_ff;
   logic signed [CZ_W-1:0]   cz_ff;

   logic                ru_start, ru_done;
   logic signed [32:0]  ru_d;
   logic [31:0]         ru_dt;
   logic signed [31:0]  ru_rate;

   logic                accept, send;
   logic [FILL_W-1:0]   fill_next;
   logic                last_cnt;
   logic [IDX_W-1:0]    k_idx;
   logic [15:0]         tap_sel;
   logic signed [31:0]  hist_sel;
   logic signed [CX_W-1:0] mul_a;
   logic signed [16:0]  mul_b;
   logic [15:0]         dh16;
   logic [15:0]         ang, ang_off, resid;
   logic [1:0]          quad;
   logic signed [CX_W-1:0] x0, y0, xs, ys;
   logic [3:0]          step;
   logic signed [ACC_W-1:0] fir_sum, gain_sum;

   ptvs_rate_unit u_rate (
      .clock (clock),
      .reset (reset),
      .start (ru_start),
      .d     (ru_d),
      .dt    (ru_dt),
      .done  (ru_done),
      .rate  (ru_rate)
   );

   // handshake
   assign accept    = req_valid && !req_stall;
   assign send      = (state_ff == ST_SEND) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign fill_next = (fill_ff == FILL_W'(TAPS + 1)) ? fill_ff : fill_ff + 1'b1;

   // differences against the newest stored pose
   always_comb begin
      ru_dt = in_ff.stamp_us - stamp_ring_ff[TAPS-1];
      dh16  = in_ff.heading - hd_ring_ff[TAPS-1];
      case (ch_ff)
         2'd0:    ru_d = {in_ff.pos_x[31], in_ff.pos_x}
                       - {x_ring_ff[TAPS-1][31], x_ring_ff[TAPS-1]};
         2'd1:    ru_d = {in_ff.pos_y[31], in_ff.pos_y}
                       - {y_ring_ff[TAPS-1][31], y_ring_ff[TAPS-1]};
         default: ru_d = (dh16 == 16'h8000) ? 33'sd32768 : {{17{dh16[15]}}, dh16};
      endcase
   end

   // fir operand selection
   always_comb begin
      k_idx = (cnt_ff < CNT_W'(TAPS)) ? IDX_W'(cnt_ff) : '0;
      if (cnt_ff < CNT_W'(NUM_TAP_REGS) && cnt_ff < CNT_W'(TAPS))
         tap_sel = tap_ff[TAP_IDX_W'(cnt_ff)];
      else
         tap_sel = 16'd0;
      case (ch_ff)
         2'd0:    hist_sel = vx_hist_ff[k_idx];
         2'd1:    hist_sel = vy_hist_ff[k_idx];
         default: hist_sel = wz_hist_ff[k_idx];
      endcase
   end

   // shared multiplier operands: fir taps or cordic gain halves
   always_comb begin
      if (state_ff == ST_GAIN) begin
         mul_a = cnt_ff[1] ? cy_ff : cx_ff;
         mul_b = cnt_ff[0] ? $signed({1'b0, GAIN_HI}) : $signed({1'b0, GAIN_LO});
      end else begin
         mul_a = CX_W'(hist_sel);
         mul_b = $signed({1'b0, tap_sel});
      end
   end

   // quarter turn split and cordic step
   always_comb begin
      ang     = 16'd0 - in_ff.heading;
      ang_off = ang + 16'd8192;
      quad    = ang_off[15:14];
      resid   = ang - {quad, 14'd0};
      case (quad)
         2'd0:    begin x0 = CX_W'(fir_ff[0]);    y0 = CX_W'(fir_ff[1]);    end
         2'd1:    begin x0 = -CX_W'(fir_ff[1]);   y0 = CX_W'(fir_ff[0]);    end
         2'd2:    begin x0 = -CX_W'(fir_ff[0]);   y0 = -CX_W'(fir_ff[1]);   end
         default: begin x0 = CX_W'(fir_ff[1]);    y0 = -CX_W'(fir_ff[0]);   end
      endcase
      step = 4'(cnt_ff - 1'b1);
      xs   = cx_ff >>> step;
      ys   = cy_ff >>> step;
      fir_sum  = (acc_ff + ACC_W'(prod_ff) + ACC_W'(32768)) >>> 16;
      gain_sum = (acc_ff + (ACC_W'(prod_ff) <<< 15) + ACC_W'(536870912)) >>> 30;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (fill_ff == '0) ? ST_SHIFT : ST_RATE_GO;
         end
         ST_RATE_GO:   state_in = ST_RATE_WAIT;
         ST_RATE_WAIT: begin
            if (ru_done) state_in = (ch_ff == 2'd2) ? ST_SHIFT : ST_RATE_GO;
         end
         ST_SHIFT: begin
            state_in = (fill_next == FILL_W'(TAPS + 1)) ? ST_FIR : ST_IDLE;
         end
         ST_FIR: begin
            if (last_cnt && ch_ff == 2'd2) state_in = transform_ff ? ST_ROT : ST_SEND;
         end
         ST_ROT: begin
            if (last_cnt) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            if (last_cnt) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (send) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      ru_start  = (state_ff == ST_RATE_GO);
      case (state_ff)
         ST_FIR:  last_cnt = (cnt_ff == CNT_W'(TAPS));
         ST_ROT:  last_cnt = (cnt_ff == CNT_W'(CORDIC_STEPS));
         ST_GAIN: last_cnt = (cnt_ff == CNT_W'(4));
         default: last_cnt = 1'b0;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         transform_ff <= 1'b0;
         for (int i = 0; i < NUM_TAP_REGS; i++) tap_ff[i] <= TAP_RESET[i];
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SHIFT) fill_ff <= fill_next;
         if (state_in != state_ff || last_cnt) cnt_ff <= '0;
         else                                  cnt_ff <= cnt_ff + 1'b1;
         if (accept) ch_ff <= 2'd0;
         else if (state_ff == ST_RATE_WAIT && ru_done && ch_ff != 2'd2) ch_ff <= ch_ff + 2'd1;
         else if (state_ff == ST_SHIFT) ch_ff <= 2'd0;
         else if (state_ff == ST_FIR && last_cnt) ch_ff <= ch_ff + 2'd1;
         if (send)           rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            if (csr_index == CSR_TRANSFORM)
               transform_ff <= csr_data[0];
            else if (csr_index >= CSR_TAP_FIRST
                     && csr_index < CSR_TAP_FIRST + CSR_IDX_W'(NUM_TAP_REGS)
                     && int'(csr_index) <= TAPS)
               tap_ff[TAP_IDX_W'(csr_index - CSR_TAP_FIRST)] <= csr_data;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (accept) in_ff <= req_word;
      case (state_ff)
         ST_RATE_WAIT: begin
            if (ru_done) rate_new_ff[ch_ff] <= ru_rate;
         end
         ST_SHIFT: begin
            for (int i = 0; i < TAPS - 1; i++) begin
               stamp_ring_ff[i] <= stamp_ring_ff[i+1];
               x_ring_ff[i]     <= x_ring_ff[i+1];
               y_ring_ff[i]     <= y_ring_ff[i+1];
               hd_ring_ff[i]    <= hd_ring_ff[i+1];
            end
            stamp_ring_ff[TAPS-1] <= in_ff.stamp_us;
            x_ring_ff[TAPS-1]     <= in_ff.pos_x;
            y_ring_ff[TAPS-1]     <= in_ff.pos_y;
            hd_ring_ff[TAPS-1]    <= in_ff.heading;
            if (fill_ff != '0) begin
               for (int i = 0; i < TAPS - 1; i++) begin
                  vx_hist_ff[i] <= vx_hist_ff[i+1];
                  vy_hist_ff[i] <= vy_hist_ff[i+1];
                  wz_hist_ff[i] <= wz_hist_ff[i+1];
               end
               vx_hist_ff[TAPS-1] <= rate_new_ff[0];
               vy_hist_ff[TAPS-1] <= rate_new_ff[1];
               wz_hist_ff[TAPS-1] <= rate_new_ff[2];
            end
         end
         ST_FIR: begin
            if (cnt_ff == '0)  acc_ff <= '0;
            else if (last_cnt) fir_ff[ch_ff] <= sat32(fir_sum);
            else               acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         ST_ROT: begin
            if (cnt_ff == '0) begin
               cx_ff <= x0;
               cy_ff <= y0;
               cz_ff <= {resid[15], resid, 8'd0};
            end else if (cz_ff >= 0) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - cordic_atan(step);
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + cordic_atan(step);
            end
         end
         ST_GAIN: begin
            case (cnt_ff)
               5'd1:    acc_ff <= ACC_W'(prod_ff);
               5'd2:    fir_ff[0] <= sat32(gain_sum);
               5'd3:    acc_ff <= ACC_W'(prod_ff);
               5'd4:    fir_ff[1] <= sat32(gain_sum);
               default: begin
               end
            endcase
         end
         ST_SEND: begin
            if (send) begin
               rsp_ff.mid_stamp_us <= stamp_ring_ff[MID];
               rsp_ff.mid_pos_x    <= x_ring_ff[MID];
               rsp_ff.mid_pos_y    <= y_ring_ff[MID];
               rsp_ff.mid_heading  <= hd_ring_ff[MID];
               rsp_ff.vel_x        <= fir_ff[0];
               rsp_ff.vel_y        <= fir_ff[1];
               rsp_ff.yaw_rate     <= fir_ff[2];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hdl/ptvs_rate_unit.sv =====
// serial rate unit: rate = round(d * 1e6 / dt), saturated to 32 bits
// shift-add multiply one bit a cycle, restoring divide one bit a cycle; uses ptvs_pkg
module ptvs_rate_unit
   import ptvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] d,
   input  logic        [31:0] dt,
   output logic               done,
   output logic signed [31:0] rate
);

   ptvs_ru_state_type state_ff, state_in;
   logic [5:0]           cnt_ff;
   logic [32:0]          mag_ff;
   logic [QUO_BITS-1:0]  acc_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          dt_ff;
   logic                 neg_ff;
   logic signed [31:0]   rate_ff;

   logic [QUO_BITS-1:0]  mul_step;
   logic [32:0]          trial;
   logic                 fits;
   logic [32:0]          qsat;

   // one multiply step and one divide step
   always_comb begin
      mul_step = {acc_ff[QUO_BITS-2:0], 1'b0}
               + (US_PER_S[5'(MUL_BITS - 1) - cnt_ff[4:0]] ? QUO_BITS'(mag_ff)
                                                           : {QUO_BITS{1'b0}});
      trial = {rem_ff, acc_ff[QUO_BITS-1]};
      fits  = trial >= {1'b0, dt_ff};
      qsat  = (acc_ff > QUO_BITS'(33'h0_8000_0000)) ? 33'h0_8000_0000 : acc_ff[32:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RU_IDLE: begin
            if (start) state_in = (dt == 32'd0) ? RU_DONE : RU_MUL;
         end
         RU_MUL: begin
            if (cnt_ff == 6'(MUL_BITS - 1)) state_in = RU_DIV;
         end
         RU_DIV: begin
            if (cnt_ff == 6'(QUO_BITS - 1)) state_in = RU_SAT;
         end
         RU_SAT:  state_in = RU_DONE;
         RU_DONE: state_in = RU_IDLE;
         default: state_in = RU_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == RU_DONE);
      rate = rate_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RU_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) cnt_ff <= '0;
         else                      cnt_ff <= cnt_ff + 6'd1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         RU_IDLE: begin
            if (start) begin
               dt_ff  <= dt;
               neg_ff <= d[32];
               mag_ff <= d[32] ? 33'(-d) : 33'(d);
               acc_ff <= '0;
               rem_ff <= '0;
               if (d == 33'sd0)   rate_ff <= 32'sd0;
               else if (d[32])    rate_ff <= 32'sh8000_0000;
               else               rate_ff <= 32'sh7FFF_FFFF;
            end
         end
         RU_MUL: begin
            if (cnt_ff == 6'(MUL_BITS - 1))
               acc_ff <= mul_step + QUO_BITS'(dt_ff >> 1);
            else
               acc_ff <= mul_step;
         end
         RU_DIV: begin
            rem_ff <= fits ? 32'(trial - {1'b0, dt_ff}) : trial[31:0];
            acc_ff <= {acc_ff[QUO_BITS-2:0], fits};
         end
         RU_SAT: begin
            if (neg_ff)
               rate_ff <= 32'(-qsat);
            else if (qsat > 33'h0_7FFF_FFFF)
               rate_ff <= 32'sh7FFF_FFFF;
            else
               rate_ff <= qsat[31:0];
         end
         default: begin
         end
      endcase
   end

endmodule
